>>> rtl/two_axis_step_clamped_mover_assert.svh
// Assertion macros for the two-axis step mover.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef TWO_AXIS_STEP_CLAMPED_MOVER_ASSERT_SVH
`define TWO_AXIS_STEP_CLAMPED_MOVER_ASSERT_SVH

// same-cycle implication
`define TASCM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tascm: same-cycle check failed");

// next-cycle implication
`define TASCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tascm: next-cycle check failed");

`endif

>>> rtl/tascm_pkg.sv
// Shared types and constants for the two-axis step mover.
// No dependencies; imported by tascm_mac, the top level and the testbench files.
`timescale 1ns / 1ps

package tascm_pkg;

    localparam int ANGLE_WIDTH        = 32;
    localparam int SCALE_WIDTH        = 28;
    localparam int CAP_WIDTH          = 6;
    localparam int REMAIN_WIDTH       = 32;
    localparam int POSITION_WIDTH_DEF = 32;

    // |3b - 2a| < 5 * 2^31 fits in 34 bits, split into two 17-bit slices
    localparam int MAG_WIDTH   = 34;
    localparam int SLICE_WIDTH = MAG_WIDTH / 2;
    localparam int PROD_WIDTH  = SLICE_WIDTH + SCALE_WIDTH;
    localparam int ACC_WIDTH   = MAG_WIDTH + SCALE_WIDTH;
    localparam int FRAC_DROP   = 32;
    localparam int QUOT_WIDTH  = ACC_WIDTH - FRAC_DROP;

    localparam int ADDR_WIDTH    = 3;
    localparam int DATA_WIDTH    = 32;
    localparam int REG_INDEX_BIT = 2;

    localparam logic [SCALE_WIDTH-1:0] STEP_SCALE_RESET = 28'd133508843;
    localparam logic [CAP_WIDTH-1:0]   STEP_CAP_RESET   = 6'd12;

    localparam logic REG_STEP_SCALE = 1'b0;
    localparam logic REG_STEP_CAP   = 1'b1;

    localparam logic MODE_MOVE  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_TARGET,
        ST_DELTA,
        ST_PLAN,
        ST_REMAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                          mode;
        logic signed [ANGLE_WIDTH-1:0] angle_a;
        logic signed [ANGLE_WIDTH-1:0] angle_b;
    } move_req_t;

    typedef struct packed {
        logic                           pulse_a;
        logic                           reverse_a;
        logic                           pulse_b;
        logic                           reverse_b;
        logic signed [REMAIN_WIDTH-1:0] remaining_a;
        logic signed [REMAIN_WIDTH-1:0] remaining_b;
        logic                           final_item;
    } step_res_t;

    typedef struct packed {
        logic mul_en;
        logic mul_hi;
        logic acc_load;
        logic acc_add;
    } mac_ctrl_t;

endpackage

>>> rtl/tascm_mac.sv
// Shared multiply-accumulate unit: |operand| * step_scale in two 17-bit slices.
// Depends on tascm_pkg.
`timescale 1ns / 1ps

module tascm_mac (
    input  logic                                clk,
    input  tascm_pkg::mac_ctrl_t                ctrl,
    input  logic [tascm_pkg::MAG_WIDTH-1:0]     operand,
    input  logic [tascm_pkg::SCALE_WIDTH-1:0]   scale,
    output logic [tascm_pkg::QUOT_WIDTH-1:0]    quotient
);
    import tascm_pkg::*;

    logic [SLICE_WIDTH-1:0] slice;
    logic [PROD_WIDTH-1:0]  prod_reg, prod_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;

    assign slice = ctrl.mul_hi ? operand[MAG_WIDTH-1 -: SLICE_WIDTH]
                               : operand[SLICE_WIDTH-1:0];

    always_comb
    begin
        prod_next = prod_reg;
        if (ctrl.mul_en)
        begin
            prod_next = slice * scale;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_load)
        begin
            acc_next = ACC_WIDTH'(prod_reg);
        end
        else if (ctrl.acc_add)
        begin
            // product never reaches 2^62, no carry out
            acc_next = acc_reg + (ACC_WIDTH'(prod_reg) << SLICE_WIDTH);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // drop 32 fraction bits; sign is applied by the caller (round toward zero)
    assign quotient = acc_reg[ACC_WIDTH-1:FRAC_DROP];

endmodule

>>> rtl/two_axis_step_clamped_mover.sv
// Two-axis step mover: a move request gives max(1, N) step results, where N is the
// larger clamped step count of the two motors (at most step_cap). Both targets go
// through one shared 17x28 multiplier, two slices per axis, then delta, clamp and
// odometer update, then one step result per cycle while out_stall is low. in_stall
// stays high for the whole move. A clear request is taken while idle and gives no
// result. Depends on tascm_pkg, tascm_mac and the assertion header.
`timescale 1ns / 1ps

`include "two_axis_step_clamped_mover_assert.svh"

module two_axis_step_clamped_mover #(
    parameter int POSITION_WIDTH = tascm_pkg::POSITION_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tascm_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [tascm_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [tascm_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tascm_pkg::move_req_t              in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tascm_pkg::step_res_t              out_data
);
    import tascm_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int DW = PW + 1;
    localparam int TW = ((QUOT_WIDTH > PW) ? QUOT_WIDTH : PW) + 1;
    localparam int RW = ((DW > REMAIN_WIDTH) ? DW : REMAIN_WIDTH) + 1;

    localparam logic signed [DW-1:0] POS_MAX = {2'b00, {(PW-1){1'b1}}};
    localparam logic signed [DW-1:0] POS_MIN = {2'b11, {(PW-1){1'b0}}};
    localparam logic [TW-1:0] LIM_POS = {{(TW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic [TW-1:0] LIM_NEG = LIM_POS + 1'b1;
    localparam logic signed [RW-1:0] REM_MAX =
        {{(RW-REMAIN_WIDTH+1){1'b0}}, {(REMAIN_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0] REM_MIN =
        {{(RW-REMAIN_WIDTH+1){1'b1}}, {(REMAIN_WIDTH-1){1'b0}}};

    function automatic logic signed [DW-1:0] widen(input logic signed [PW-1:0] v);
        return {v[PW-1], v};
    endfunction

    function automatic logic [DW-1:0] n_a_ext_w(input logic [CAP_WIDTH-1:0] n);
        return {{(DW-CAP_WIDTH){1'b0}}, n};
    endfunction

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [DW-1:0] v);
        logic signed [PW-1:0] r;
        if (v > POS_MAX)
        begin
            r = POS_MAX[PW-1:0];
        end
        else if (v < POS_MIN)
        begin
            r = POS_MIN[PW-1:0];
        end
        else
        begin
            r = v[PW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [REMAIN_WIDTH-1:0] sat_rem(
        input logic signed [DW-1:0] v
    );
        logic signed [RW-1:0]           x;
        logic signed [REMAIN_WIDTH-1:0] r;
        x = {{(RW-DW){v[DW-1]}}, v};
        if (x > REM_MAX)
        begin
            r = REM_MAX[REMAIN_WIDTH-1:0];
        end
        else if (x < REM_MIN)
        begin
            r = REM_MIN[REMAIN_WIDTH-1:0];
        end
        else
        begin
            r = x[REMAIN_WIDTH-1:0];
        end
        return r;
    endfunction

    // control
    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   out_valid_reg, out_valid_next;
    logic [SCALE_WIDTH-1:0] scale_reg, scale_next;
    logic [CAP_WIDTH-1:0]   cap_reg, cap_next;
    logic signed [PW-1:0]   pos_a_reg, pos_a_next, pos_b_reg, pos_b_next;

    // payload
    logic signed [ANGLE_WIDTH-1:0] angle_a_reg, angle_a_next, angle_b_reg, angle_b_next;
    logic [MAG_WIDTH-1:0]   mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;
    logic                   neg_a_reg, neg_a_next, neg_b_reg, neg_b_next;
    logic signed [PW-1:0]   tgt_a_reg, tgt_a_next, tgt_b_reg, tgt_b_next;
    logic signed [DW-1:0]   delta_a_reg, delta_a_next, delta_b_reg, delta_b_next;
    logic [CAP_WIDTH-1:0]   n_a_reg, n_a_next, n_b_reg, n_b_next;
    logic                   rev_a_reg, rev_a_next, rev_b_reg, rev_b_next;
    logic signed [REMAIN_WIDTH-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [CAP_WIDTH-1:0]   cnt_reg, cnt_next, idx_reg, idx_next;
    step_res_t              out_data_reg, out_data_next;

    // combinational
    logic                   accept;
    logic                   cfg_write;
    logic                   reg_index;
    logic                   slot_free;
    logic                   emit_load;
    logic                   emit_last;
    mac_ctrl_t              mac_ctrl;
    logic [MAG_WIDTH-1:0]   mac_operand;
    logic [QUOT_WIDTH-1:0]  quotient;
    logic signed [MAG_WIDTH:0] ext_a, ext_b, mix_b, abs_a, abs_b;
    logic                   cur_neg;
    logic [TW-1:0]          q_ext;
    logic [TW-1:0]          q_neg;
    logic signed [PW-1:0]   tgt_new;
    logic [DW-1:0]          mag_da, mag_db;
    logic [CAP_WIDTH-1:0]   n_a_new, n_b_new;
    logic [DW-1:0]          n_a_ext, n_b_ext;
    logic [CAP_WIDTH-1:0]   cnt_max;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[REG_INDEX_BIT];

    always_comb
    begin
        scale_next = scale_reg;
        cap_next   = cap_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_STEP_SCALE: scale_next = pwdata[SCALE_WIDTH-1:0];
                REG_STEP_CAP:   cap_next   = pwdata[CAP_WIDTH-1:0];
                default:        scale_next = scale_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_STEP_SCALE: prdata = DATA_WIDTH'(scale_reg);
            REG_STEP_CAP:   prdata = DATA_WIDTH'(cap_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_last = (idx_reg == (cnt_reg - 1'b1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_data.mode != MODE_CLEAR)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_TARGET;
            ST_TARGET: state_next = axis_reg ? ST_DELTA : ST_MUL_LO;
            ST_DELTA:  state_next = ST_PLAN;
            ST_PLAN:   state_next = ST_REMAIN;
            ST_REMAIN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free && emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        mac_ctrl  = '0;
        emit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_MUL_LO: mac_ctrl.mul_en = 1'b1;
            ST_MUL_HI:
            begin
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.mul_hi   = 1'b1;
                mac_ctrl.acc_load = 1'b1;
            end
            ST_ACC:    mac_ctrl.acc_add = 1'b1;
            ST_EMIT:   emit_load = slot_free;
            default:   in_stall = 1'b1;
        endcase
    end

    // ---------------- shared multiplier ----------------
    assign mac_operand = axis_reg ? mag_b_reg : mag_a_reg;

    tascm_mac u_mac (
        .clk      (clk),
        .ctrl     (mac_ctrl),
        .operand  (mac_operand),
        .scale    (scale_reg),
        .quotient (quotient)
    );

    // ---------------- datapath ----------------
    assign ext_a = {{(MAG_WIDTH+1-ANGLE_WIDTH){angle_a_reg[ANGLE_WIDTH-1]}}, angle_a_reg};
    assign ext_b = {{(MAG_WIDTH+1-ANGLE_WIDTH){angle_b_reg[ANGLE_WIDTH-1]}}, angle_b_reg};
    assign mix_b = (ext_b <<< 1) + ext_b - (ext_a <<< 1);
    assign abs_a = ext_a[MAG_WIDTH] ? -ext_a : ext_a;
    assign abs_b = mix_b[MAG_WIDTH] ? -mix_b : mix_b;

    // signed target from magnitude quotient, saturated to the odometer range
    assign cur_neg = axis_reg ? neg_b_reg : neg_a_reg;
    assign q_ext   = {{(TW-QUOT_WIDTH){1'b0}}, quotient};
    assign q_neg   = -q_ext;

    always_comb
    begin
        if (cur_neg)
        begin
            tgt_new = (q_ext > LIM_NEG) ? POS_MIN[PW-1:0] : q_neg[PW-1:0];
        end
        else
        begin
            tgt_new = (q_ext > LIM_POS) ? POS_MAX[PW-1:0] : q_ext[PW-1:0];
        end
    end

    assign mag_da  = delta_a_reg[DW-1] ? -delta_a_reg : delta_a_reg;
    assign mag_db  = delta_b_reg[DW-1] ? -delta_b_reg : delta_b_reg;
    assign n_a_new = (mag_da < DW'(cap_reg)) ? mag_da[CAP_WIDTH-1:0] : cap_reg;
    assign n_b_new = (mag_db < DW'(cap_reg)) ? mag_db[CAP_WIDTH-1:0] : cap_reg;
    assign n_a_ext = {{(DW-CAP_WIDTH){1'b0}}, n_a_reg};
    assign n_b_ext = {{(DW-CAP_WIDTH){1'b0}}, n_b_reg};
    assign cnt_max = (n_a_reg > n_b_reg) ? n_a_reg : n_b_reg;

    always_comb
    begin
        axis_next     = axis_reg;
        pos_a_next    = pos_a_reg;
        pos_b_next    = pos_b_reg;
        angle_a_next  = angle_a_reg;
        angle_b_next  = angle_b_reg;
        mag_a_next    = mag_a_reg;
        mag_b_next    = mag_b_reg;
        neg_a_next    = neg_a_reg;
        neg_b_next    = neg_b_reg;
        tgt_a_next    = tgt_a_reg;
        tgt_b_next    = tgt_b_reg;
        delta_a_next  = delta_a_reg;
        delta_b_next  = delta_b_reg;
        n_a_next      = n_a_reg;
        n_b_next      = n_b_reg;
        rev_a_next    = rev_a_reg;
        rev_b_next    = rev_b_reg;
        rem_a_next    = rem_a_reg;
        rem_b_next    = rem_b_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        out_data_next = out_data_reg;

        if (accept)
        begin
            angle_a_next = in_data.angle_a;
            angle_b_next = in_data.angle_b;
            axis_next    = 1'b0;
            if (in_data.mode == MODE_CLEAR)
            begin
                pos_a_next = '0;
                pos_b_next = '0;
            end
        end

        case (state_reg)
            ST_PREP:
            begin
                mag_a_next = abs_a[MAG_WIDTH-1:0];
                mag_b_next = abs_b[MAG_WIDTH-1:0];
                neg_a_next = ext_a[MAG_WIDTH];
                neg_b_next = mix_b[MAG_WIDTH];
            end
            ST_TARGET:
            begin
                if (axis_reg)
                begin
                    tgt_b_next = tgt_new;
                end
                else
                begin
                    tgt_a_next = tgt_new;
                    axis_next  = 1'b1;
                end
            end
            ST_DELTA:
            begin
                delta_a_next = widen(tgt_a_reg) - widen(pos_a_reg);
                delta_b_next = widen(tgt_b_reg) - widen(pos_b_reg);
            end
            ST_PLAN:
            begin
                n_a_next   = n_a_new;
                n_b_next   = n_b_new;
                rev_a_next = delta_a_reg[DW-1];
                rev_b_next = delta_b_reg[DW-1];
                pos_a_next = sat_pos(delta_a_reg[DW-1]
                                     ? widen(pos_a_reg) - $signed(n_a_ext_w(n_a_new))
                                     : widen(pos_a_reg) + $signed(n_a_ext_w(n_a_new)));
                pos_b_next = sat_pos(delta_b_reg[DW-1]
                                     ? widen(pos_b_reg) - $signed(n_a_ext_w(n_b_new))
                                     : widen(pos_b_reg) + $signed(n_a_ext_w(n_b_new)));
            end
            ST_REMAIN:
            begin
                rem_a_next = sat_rem(widen(tgt_a_reg) - widen(pos_a_reg));
                rem_b_next = sat_rem(widen(tgt_b_reg) - widen(pos_b_reg));
                cnt_next   = (cnt_max == '0) ? CAP_WIDTH'(1) : cnt_max;
                idx_next   = '0;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase

        if (emit_load)
        begin
            out_data_next.pulse_a     = ({{(DW-CAP_WIDTH){1'b0}}, idx_reg} < n_a_ext);
            out_data_next.reverse_a   = rev_a_reg;
            out_data_next.pulse_b     = ({{(DW-CAP_WIDTH){1'b0}}, idx_reg} < n_b_ext);
            out_data_next.reverse_b   = rev_b_reg;
            out_data_next.remaining_a = emit_last ? rem_a_reg : '0;
            out_data_next.remaining_b = emit_last ? rem_b_reg : '0;
            out_data_next.final_item  = emit_last;
            idx_next                  = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            scale_reg     <= STEP_SCALE_RESET;
            cap_reg       <= STEP_CAP_RESET;
            pos_a_reg     <= '0;
            pos_b_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
            scale_reg     <= scale_next;
            cap_reg       <= cap_next;
            pos_a_reg     <= pos_a_next;
            pos_b_reg     <= pos_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_a_reg  <= angle_a_next;
        angle_b_reg  <= angle_b_next;
        mag_a_reg    <= mag_a_next;
        mag_b_reg    <= mag_b_next;
        neg_a_reg    <= neg_a_next;
        neg_b_reg    <= neg_b_next;
        tgt_a_reg    <= tgt_a_next;
        tgt_b_reg    <= tgt_b_next;
        delta_a_reg  <= delta_a_next;
        delta_b_reg  <= delta_b_next;
        n_a_reg      <= n_a_next;
        n_b_reg      <= n_b_next;
        rev_a_reg    <= rev_a_next;
        rev_b_reg    <= rev_b_next;
        rem_a_reg    <= rem_a_next;
        rem_b_reg    <= rem_b_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    // a move keeps the input side closed on the following cycle
    `TASCM_ASSERT_NEXT(a_move_busy, in_valid && !in_stall && in_data.mode == MODE_MOVE, in_stall)
    // results of one move leave back to back once the sink takes them
    `TASCM_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !out_data.final_item, out_valid)
    // when the sequencer is idle only the last result of a move can be pending
    `TASCM_ASSERT_SAME(a_idle_final, !in_stall && out_valid, out_data.final_item)

endmodule

>>> tb/step_pulse_checker.sv
`timescale 1ns / 1ps
// Step checker for the two-axis mover: tracks register writes and requests,
// predicts every step result from its own odometers and compares in order.
// Depends on tascm_pkg.

module step_pulse_checker #(
    parameter int ODOM_WIDTH = tascm_pkg::POSITION_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [tascm_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [tascm_pkg::DATA_WIDTH-1:0] pwdata,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  tascm_pkg::move_req_t             in_data,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  tascm_pkg::step_res_t             out_data,
    output int                               fail_count,
    output int                               pending,
    output int                               steps_checked
);
    import tascm_pkg::*;

    logic [SCALE_WIDTH-1:0] scale_q;
    logic [CAP_WIDTH-1:0]   cap_q;
    longint                 odom_a;
    longint                 odom_b;
    step_res_t              due_steps[$];

    function automatic longint saturate(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // drop 32 fraction bits, rounding toward zero
    function automatic longint drop_frac(input longint p);
        if (p < 0)
            return -((-p) >> 32);
        return p >> 32;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("step mismatch at %0t: %s", $time, what);
    endtask

    task automatic compare_field(input string field, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s got %0d, want %0d",
                                      steps_checked, field, got, want));
    endtask

    task automatic plan_move(input logic signed [ANGLE_WIDTH-1:0] ang_a,
                             input logic signed [ANGLE_WIDTH-1:0] ang_b);
        longint    a;
        longint    b;
        longint    s;
        longint    cap;
        longint    tgt_a;
        longint    tgt_b;
        longint    dlt_a;
        longint    dlt_b;
        longint    n_a;
        longint    n_b;
        longint    cnt;
        longint    slot;
        step_res_t res;
        a     = longint'(ang_a);
        b     = longint'(ang_b);
        s     = longint'(scale_q);
        cap   = longint'(cap_q);
        tgt_a = saturate(drop_frac(a * s), ODOM_WIDTH);
        tgt_b = saturate(drop_frac((3 * b - 2 * a) * s), ODOM_WIDTH);
        dlt_a = tgt_a - odom_a;
        dlt_b = tgt_b - odom_b;
        n_a   = (dlt_a < 0) ? -dlt_a : dlt_a;
        n_b   = (dlt_b < 0) ? -dlt_b : dlt_b;
        if (n_a > cap)
            n_a = cap;
        if (n_b > cap)
            n_b = cap;
        cnt = (n_a > n_b) ? n_a : n_b;
        if (cnt < 1)
            cnt = 1;
        odom_a = saturate((dlt_a < 0) ? odom_a - n_a : odom_a + n_a, ODOM_WIDTH);
        odom_b = saturate((dlt_b < 0) ? odom_b - n_b : odom_b + n_b, ODOM_WIDTH);
        for (slot = 0; slot < cnt; slot++)
        begin
            res.pulse_a    = (slot < n_a);
            res.reverse_a  = (dlt_a < 0);
            res.pulse_b    = (slot < n_b);
            res.reverse_b  = (dlt_b < 0);
            res.final_item = (slot == cnt - 1);
            // leftover distance only rides on the last step of the request
            res.remaining_a = res.final_item
                              ? REMAIN_WIDTH'(saturate(tgt_a - odom_a, REMAIN_WIDTH)) : '0;
            res.remaining_b = res.final_item
                              ? REMAIN_WIDTH'(saturate(tgt_b - odom_b, REMAIN_WIDTH)) : '0;
            due_steps.push_back(res);
        end
    endtask

    task automatic check_step(input step_res_t got);
        step_res_t want;
        if (due_steps.size() == 0)
        begin
            report_mismatch($sformatf("step result %h with no request waiting", got));
            return;
        end
        want = due_steps.pop_front();
        steps_checked++;
        compare_field("pulse_a", got.pulse_a, want.pulse_a);
        compare_field("reverse_a", got.reverse_a, want.reverse_a);
        compare_field("pulse_b", got.pulse_b, want.pulse_b);
        compare_field("reverse_b", got.reverse_b, want.reverse_b);
        compare_field("remaining_a", got.remaining_a, want.remaining_a);
        compare_field("remaining_b", got.remaining_b, want.remaining_b);
        compare_field("final_item", got.final_item, want.final_item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q       = STEP_SCALE_RESET;
            cap_q         = STEP_CAP_RESET;
            odom_a        = 0;
            odom_b        = 0;
            fail_count    = 0;
            steps_checked = 0;
            due_steps.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_WIDTH-1:REG_INDEX_BIT] == REG_STEP_SCALE)
                    scale_q = pwdata[SCALE_WIDTH-1:0];
                else
                    cap_q = pwdata[CAP_WIDTH-1:0];
            end
            if (out_valid && !out_stall)
                check_step(out_data);
            if (in_valid && !in_stall)
            begin
                if (in_data.mode == MODE_CLEAR)
                begin
                    odom_a = 0;
                    odom_b = 0;
                end
                else
                    plan_move(in_data.angle_a, in_data.angle_b);
            end
            pending <= due_steps.size();
        end
    end

endmodule

>>> tb/tb_two_axis_step_clamped_mover.sv
`timescale 1ns / 1ps
// Testbench top for the two-axis step mover: clock, reset, register writes and
// request stimulus under several idle/stall mixes; verdict from the step checker.
// Depends on tascm_pkg, two_axis_step_clamped_mover and step_pulse_checker.

module tb_two_axis_step_clamped_mover;
    import tascm_pkg::*;

    localparam int ODOM_WIDTH  = POSITION_WIDTH_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 24;
    localparam int PHASE_ITEMS = 85;

    localparam logic [ANGLE_WIDTH-1:0] ANG_MAX = 32'h7FFF_FFFF;
    localparam logic [ANGLE_WIDTH-1:0] ANG_MIN = 32'h8000_0000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_WIDTH-1:0] paddr;
    logic [DATA_WIDTH-1:0] pwdata;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    move_req_t             in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    step_res_t             out_data;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int reqs_sent    = 0;
    int clears_sent  = 0;
    int reg_writes   = 0;
    int fail_count;
    int pending;
    int steps_checked;

    two_axis_step_clamped_mover #(
        .POSITION_WIDTH(ODOM_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    step_pulse_checker #(
        .ODOM_WIDTH(ODOM_WIDTH)
    ) step_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .steps_checked(steps_checked)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: cycles with no request and no step result accepted
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no progress for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_req(input move_req_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reqs_sent++;
        if (req.mode == MODE_CLEAR)
            clears_sent++;
    endtask

    task automatic send_move(input logic [ANGLE_WIDTH-1:0] ang_a,
                             input logic [ANGLE_WIDTH-1:0] ang_b);
        move_req_t req;
        req.mode    = MODE_MOVE;
        req.angle_a = ang_a;
        req.angle_b = ang_b;
        send_req(req);
    endtask

    task automatic send_clear();
        move_req_t req;
        req.mode    = MODE_CLEAR;
        req.angle_a = $urandom();
        req.angle_b = $urandom();
        send_req(req);
    endtask

    // sender parks until every predicted step is out, then lets the block settle
    task automatic drain_pipe();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WIDTH'(idx) << REG_INDEX_BIT;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic set_regs(input logic [DATA_WIDTH-1:0] scale,
                            input logic [DATA_WIDTH-1:0] cap);
        drain_pipe();
        write_reg(REG_STEP_SCALE, scale);
        write_reg(REG_STEP_CAP, cap);
    endtask

    function automatic logic [ANGLE_WIDTH-1:0] random_angle();
        case ($urandom_range(3))
            0: return 32'($urandom_range(1023)) - 32'd512;
            1: return 32'($urandom_range(131071)) - 32'd65536;
            2: return $urandom();
            default:
                case ($urandom_range(3))
                    0: return ANG_MAX;
                    1: return ANG_MIN;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    // mostly runs of repeated moves toward one target each, so the odometers close in on it
    task automatic run_phase(input int n_items);
        int        sent;
        int        repeats;
        move_req_t req;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 5)
            begin
                send_clear();
                sent++;
            end
            else
            begin
                req.mode    = MODE_MOVE;
                req.angle_a = random_angle();
                req.angle_b = random_angle();
                repeats     = $urandom_range(1, 6);
                repeat (repeats)
                begin
                    send_req(req);
                    sent++;
                end
            end
            if ($urandom_range(99) < 4)
                drain_pipe();
        end
    endtask

    task automatic directed_moves();
        send_move(0, 0);
        send_move(100, 0);
        send_move(100, 0);
        send_move(-100, -100);
        send_move(ANG_MAX, ANG_MIN);
        send_move(ANG_MIN, ANG_MAX);
        send_move(ANG_MAX, ANG_MAX);
        send_move(ANG_MIN, ANG_MIN);
        send_clear();
        send_move(0, 0);
        // zero cap: a lone final result with no pulses
        set_regs(DATA_WIDTH'(STEP_SCALE_RESET), 0);
        send_move(1000, -1000);
        send_move(ANG_MAX, ANG_MIN);
        // upper scale bits are dropped, leaving the top scale value
        set_regs(32'hFFFF_FFFF, 63);
        send_move(-1, 1);
        send_move(ANG_MAX, ANG_MIN);
        send_move(ANG_MAX, ANG_MIN);
        send_move(ANG_MIN, ANG_MAX);
        // zero scale drags both odometers back; cap field takes only its low bits
        set_regs(0, 32'hFFFF_FFC1);
        send_move(ANG_MAX, 12345);
        send_move(-5000, 5000);
        send_clear();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_moves();

        set_regs(DATA_WIDTH'(STEP_SCALE_RESET), DATA_WIDTH'(STEP_CAP_RESET));
        run_phase(PHASE_ITEMS);

        set_regs($urandom(), 63);
        idle_pct <= 79;
        run_phase(PHASE_ITEMS);

        set_regs($urandom_range(0, 32'h0010_0000), $urandom_range(1, 8));
        idle_pct  <= 0;
        stall_pct <= 79;
        run_phase(PHASE_ITEMS);

        set_regs($urandom(), $urandom_range(0, 63));
        idle_pct  <= 30;
        stall_pct <= 30;
        run_phase(PHASE_ITEMS);

        drain_pipe();
        $display("Covered %0d requests (%0d clears) and %0d register writes", reqs_sent,
                 clears_sent, reg_writes);
        $display("across four idle/stall mixes; %0d step results checked.", steps_checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
